@@ hw/rtl/ldfm_pkg.sv @@
// ----------------------------------------------------------------------------
// ldfm_pkg: shared types and constants of the lens distortion forward map
// Fixed widths, register codes, the beat layouts between the units, and the
// saturation helpers used by the main pipeline, whose limits the normalization unit also uses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ldfm_pkg;

  // Pixel coordinates are 24-bit Q16.8; normalized values are 32-bit.
  localparam int P_W       = 24;
  localparam int Q_W       = 32;
  localparam int X_W       = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [P_W-1:0] FOCAL_RESET = 24'd256;

  // Clip limits, held wide so that any grown sum compares directly.
  localparam logic signed [X_W-1:0] Q_HI = 64'sd2147483647;
  localparam logic signed [X_W-1:0] Q_LO = -64'sd2147483648;
  localparam logic signed [X_W-1:0] P_HI = 64'sd8388607;
  localparam logic signed [X_W-1:0] P_LO = -64'sd8388608;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_FOCAL_LENGTH,
    CFG_RADIAL_K1,
    CFG_RADIAL_K2,
    CFG_RADIAL_K3,
    CFG_TANGENT_P1,
    CFG_TANGENT_P2
  } cfg_reg_t;

  // Observed point carried alongside the computation.
  typedef struct packed {
    logic signed [P_W-1:0] obs_x;
    logic signed [P_W-1:0] obs_y;
  } ldfm_obs_t;

  // Result of the normalization unit.
  typedef struct packed {
    logic signed [Q_W-1:0] u;
    logic signed [Q_W-1:0] v;
    logic                  sat;
  } ldfm_norm_t;

  function automatic logic signed [Q_W-1:0] clip_q(input logic signed [X_W-1:0] x);
    logic signed [X_W-1:0] y;
    y = x;
    if (x > Q_HI) y = Q_HI;
    if (x < Q_LO) y = Q_LO;
    return y[Q_W-1:0];
  endfunction

  function automatic logic over_q(input logic signed [X_W-1:0] x);
    return (x > Q_HI) || (x < Q_LO);
  endfunction

  function automatic logic signed [P_W-1:0] clip_p(input logic signed [X_W-1:0] x);
    logic signed [X_W-1:0] y;
    y = x;
    if (x > P_HI) y = P_HI;
    if (x < P_LO) y = P_LO;
    return y[P_W-1:0];
  endfunction

  function automatic logic over_p(input logic signed [X_W-1:0] x);
    return (x > P_HI) || (x < P_LO);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ldfm_norm.sv @@
// ----------------------------------------------------------------------------
// ldfm_norm: pipelined normalization of both coordinates
// Computes u = (ideal - center) * 2^F / focal for x and y with a restoring
// divider that retires one quotient bit per stage, truncating toward zero
// and clipping to the signed 32-bit range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldfm_norm
  import ldfm_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic signed [P_W-1:0] ideal_x,
  input  wire logic signed [P_W-1:0] ideal_y,
  input  wire logic        [P_W-1:0] center_x,
  input  wire logic        [P_W-1:0] center_y,
  input  wire logic        [P_W-1:0] focal,
  input  wire ldfm_obs_t             in_obs,
  output      logic                  out_valid,
  output      ldfm_norm_t            res,
  output      ldfm_obs_t             out_obs
);

  localparam int SH    = Q_W - COEF_FRAC_BITS;
  localparam int CMP_W = P_W + SH;
  localparam int MAG_W = P_W + 2;
  localparam int NUM_W = MAG_W + COEF_FRAC_BITS;
  localparam int STEPS = Q_W;

  logic signed [P_W-1:0] ideal  [2];
  logic        [P_W-1:0] center [2];

  assign ideal[0]  = ideal_x;
  assign ideal[1]  = ideal_y;
  assign center[0] = center_x;
  assign center[1] = center_y;

  // Front end: signed difference, magnitude, overflow test and numerator.
  logic [MAG_W-1:0] diff [2];
  logic [MAG_W-1:0] mag  [2];
  logic [NUM_W-1:0] num  [2];
  logic             sgn  [2];
  logic             big  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l] = {{2{ideal[l][P_W-1]}}, ideal[l]} - {2'b00, center[l]};
      sgn[l]  = diff[l][MAG_W-1];
      mag[l]  = sgn[l] ? (~diff[l] + MAG_W'(1)) : diff[l];
      num[l]  = NUM_W'(mag[l]) << COEF_FRAC_BITS;
      big[l]  = CMP_W'(mag[l]) >= (CMP_W'(focal) << SH);
    end
  end

  // Stage registers: stage 0 is the front end, stage s holds s quotient bits.
  logic             vld [STEPS+1];
  logic [P_W-1:0]   rem [STEPS+1][2];
  logic [Q_W-1:0]   nq  [STEPS+1][2];
  logic             neg [STEPS+1][2];
  logic             ovf [STEPS+1][2];
  ldfm_obs_t        obs [STEPS+1];

  // One compare-and-subtract per stage and lane.
  logic [P_W:0]     trial [STEPS][2];
  logic             take  [STEPS][2];

  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < 2; l++) begin
        trial[s][l] = {rem[s][l], nq[s][l][Q_W-1]};
        take[s][l]  = trial[s][l] >= {1'b0, focal};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= STEPS; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s <= STEPS; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      obs[0] <= in_obs;
      for (int l = 0; l < 2; l++) begin
        rem[0][l] <= P_W'(num[l][NUM_W-1:Q_W]);
        nq[0][l]  <= num[l][Q_W-1:0];
        neg[0][l] <= sgn[l];
        ovf[0][l] <= big[l];
      end
      for (int s = 1; s <= STEPS; s++) begin
        obs[s] <= obs[s-1];
        for (int l = 0; l < 2; l++) begin
          rem[s][l] <= take[s-1][l] ? trial[s-1][l][P_W-1:0] - focal
                                    : trial[s-1][l][P_W-1:0];
          nq[s][l]  <= {nq[s-1][l][Q_W-2:0], take[s-1][l]};
          neg[s][l] <= neg[s-1][l];
          ovf[s][l] <= ovf[s-1][l];
        end
      end
    end
  end

  // Final stage: apply the sign and clip the quotient.
  logic signed [Q_W-1:0] val  [2];
  logic                  clip [2];
  logic        [Q_W-1:0] qt   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qt[l]   = nq[STEPS][l];
      clip[l] = 1'b0;
      val[l]  = qt[l];
      if (ovf[STEPS][l]) begin
        clip[l] = 1'b1;
        val[l]  = neg[STEPS][l] ? Q_LO[Q_W-1:0] : Q_HI[Q_W-1:0];
      end else if (!neg[STEPS][l]) begin
        if (qt[l][Q_W-1]) begin
          clip[l] = 1'b1;
          val[l]  = Q_HI[Q_W-1:0];
        end
      end else begin
        if (qt[l][Q_W-1] && (|qt[l][Q_W-2:0])) begin
          clip[l] = 1'b1;
          val[l]  = Q_LO[Q_W-1:0];
        end else begin
          val[l] = ~qt[l] + Q_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.u   <= val[0];
      res.v   <= val[1];
      res.sat <= clip[0] | clip[1];
      out_obs <= obs[STEPS];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lens_distortion_forward_map.sv @@
// ----------------------------------------------------------------------------
// lens_distortion_forward_map: Brown-Conrady forward distortion, k1..k3, p1..p2
// Normalizes an ideal point, applies radial and tangential distortion, maps
// back to pixels and returns the distorted point and the residual against an
// observed point, all in fixed point with saturation flagged.
// ----------------------------------------------------------------------------
// The path from an input beat to its output beat holds 48 register stages; one
// beat per clock while the output is not stalled.
// The normalization unit holds 34 stages (front end, 32 divider stages, output);
// the distortion math adds 13 stages and then the output register.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears every valid bit and loads the configuration registers with their reset values.
`timescale 1ns / 1ps
`default_nettype none

module lens_distortion_forward_map
  import ldfm_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Fields from bit 0: ideal_x, ideal_y, observed_x, observed_y.
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [4*P_W-1:0]     s_tdata,
  // Fields from bit 0: distorted_x, distorted_y, residual_x, residual_y.
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [4*P_W-1:0]     m_tdata,
  // Field: saturated.
  output      logic [0:0]           m_tuser,
  // Register writes.
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [Q_W-1:0]       cfg_data
);

  localparam int F     = COEF_FRAC_BITS;
  localparam int ACC_W = 2 * Q_W - COEF_FRAC_BITS + 1;
  localparam int PX_W  = Q_W + P_W + 1;

  // Register file.
  logic        [P_W-1:0] center_x;
  logic        [P_W-1:0] center_y;
  logic        [P_W-1:0] focal_length;
  logic signed [Q_W-1:0] radial_k1;
  logic signed [Q_W-1:0] radial_k2;
  logic signed [Q_W-1:0] radial_k3;
  logic signed [Q_W-1:0] tangent_p1;
  logic signed [Q_W-1:0] tangent_p2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      focal_length <= FOCAL_RESET;
      radial_k1    <= '0;
      radial_k2    <= '0;
      radial_k3    <= '0;
      tangent_p1   <= '0;
      tangent_p2   <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X:     center_x     <= cfg_data[P_W-1:0];
        CFG_CENTER_Y:     center_y     <= cfg_data[P_W-1:0];
        CFG_FOCAL_LENGTH: focal_length <= cfg_data[P_W-1:0];
        CFG_RADIAL_K1:    radial_k1    <= signed'(cfg_data);
        CFG_RADIAL_K2:    radial_k2    <= signed'(cfg_data);
        CFG_RADIAL_K3:    radial_k3    <= signed'(cfg_data);
        CFG_TANGENT_P1:   tangent_p1   <= signed'(cfg_data);
        CFG_TANGENT_P2:   tangent_p2   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // A zero focal length behaves as one LSB.
  logic [P_W-1:0] focal_eff;
  assign focal_eff = (focal_length == '0) ? P_W'(1) : focal_length;

  // The pipeline moves whenever the output register can take a beat.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  ldfm_obs_t  in_obs;
  logic       n_vld;
  ldfm_norm_t n_res;
  ldfm_obs_t  n_obs;

  assign in_obs.obs_x = signed'(s_tdata[3*P_W-1:2*P_W]);
  assign in_obs.obs_y = signed'(s_tdata[4*P_W-1:3*P_W]);

  ldfm_norm #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s_tvalid),
    .ideal_x  (signed'(s_tdata[P_W-1:0])),
    .ideal_y  (signed'(s_tdata[2*P_W-1:P_W])),
    .center_x (center_x),
    .center_y (center_y),
    .focal    (focal_eff),
    .in_obs   (in_obs),
    .out_valid(n_vld),
    .res      (n_res),
    .out_obs  (n_obs)
  );

  // Valid bits of stages 1 to 13.
  logic [13:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[12:1], n_vld};
      m_tvalid <= vld[13];
    end
  end

  // Stage payload registers.
  logic signed [X_W-1:0]   uu_p1, vv_p1, uv_p1;
  logic signed [Q_W-1:0]   u1, v1, u2, v2, u3, v3, u4, v4, u5, v5;
  logic signed [Q_W-1:0]   u6, v6, u7, v7, u8, v8, u9, v9, u10, v10;
  logic                    sat1, sat2, sat3, sat4, sat5, sat6, sat7;
  logic                    sat8, sat9, sat10, sat11, sat12, sat13;
  ldfm_obs_t               obs1, obs2, obs3, obs4, obs5, obs6, obs7;
  ldfm_obs_t               obs8, obs9, obs10, obs11, obs12, obs13;
  logic signed [Q_W-1:0]   uu2, vv2, uv2, uu3, vv3, uv3;
  logic signed [Q_W-1:0]   r2_3, r2_4, r2_5, tx4, ty4, r4_5, r6_7;
  logic signed [X_W-1:0]   r4_p4, k1r2_p4, p1uv_p4, p2uv_p4;
  logic signed [ACC_W-1:0] k1r2_5, k1r2_6, k1r2_7, p1uv_5, p2uv_5, k2r4_7;
  logic signed [X_W-1:0]   p2tx_p5, p1ty_p5, r6_p6, k2r4_p6, k3r6_p8;
  logic signed [Q_W-1:0]   dpx6, dpy6, dpx7, dpy7, dpx8, dpy8;
  logic signed [Q_W-1:0]   dpx9, dpy9, dpx10, dpy10, dk9;
  logic signed [ACC_W:0]   k12_8;
  logic signed [X_W-1:0]   udk_p10, vdk_p10;
  logic signed [Q_W-1:0]   ud11, vd11;
  logic signed [PX_W-1:0]  pxp12, pyp12;
  logic signed [P_W-1:0]   dx13, dy13;

  // Wide sums ahead of each clip.
  logic signed [X_W-1:0] uu_s, vv_s, uv_s, r2_s, tx_s, ty_s, r4_s, r6_s;
  logic signed [X_W-1:0] dpx_s, dpy_s, dk_s, ud_s, vd_s, dx_s, dy_s, rx_s, ry_s;

  always_comb begin
    uu_s  = uu_p1 >>> F;
    vv_s  = vv_p1 >>> F;
    uv_s  = uv_p1 >>> F;
    r2_s  = X_W'(uu2) + X_W'(vv2);
    tx_s  = X_W'(r2_3) + (X_W'(uu3) <<< 1);
    ty_s  = X_W'(r2_3) + (X_W'(vv3) <<< 1);
    r4_s  = r4_p4 >>> F;
    dpx_s = X_W'(p1uv_5) + (p2tx_p5 >>> F);
    dpy_s = (p1ty_p5 >>> F) + X_W'(p2uv_5);
    r6_s  = r6_p6 >>> F;
    dk_s  = X_W'(k12_8) + (k3r6_p8 >>> F);
    ud_s  = X_W'(u10) + (udk_p10 >>> F) + X_W'(dpx10);
    vd_s  = X_W'(v10) + (vdk_p10 >>> F) + X_W'(dpy10);
    dx_s  = X_W'(pxp12 >>> F) + X_W'(signed'({1'b0, center_x}));
    dy_s  = X_W'(pyp12 >>> F) + X_W'(signed'({1'b0, center_y}));
    rx_s  = X_W'(obs13.obs_x) - X_W'(dx13);
    ry_s  = X_W'(obs13.obs_y) - X_W'(dy13);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: squares and cross product of the normalized point.
      uu_p1 <= n_res.u * n_res.u;
      vv_p1 <= n_res.v * n_res.v;
      uv_p1 <= n_res.u * n_res.v;
      u1    <= n_res.u;
      v1    <= n_res.v;
      sat1  <= n_res.sat;
      obs1  <= n_obs;

      // Stage 2: rescale and clip the products.
      uu2  <= clip_q(uu_s);
      vv2  <= clip_q(vv_s);
      uv2  <= clip_q(uv_s);
      sat2 <= sat1 | over_q(uu_s) | over_q(vv_s) | over_q(uv_s);
      u2   <= u1;
      v2   <= v1;
      obs2 <= obs1;

      // Stage 3: squared radius.
      r2_3 <= clip_q(r2_s);
      sat3 <= sat2 | over_q(r2_s);
      uu3  <= uu2;
      vv3  <= vv2;
      uv3  <= uv2;
      u3   <= u2;
      v3   <= v2;
      obs3 <= obs2;

      // Stage 4: r^4, k1 term, cross tangential products, r2 + 2u^2 and r2 + 2v^2.
      r4_p4   <= r2_3 * r2_3;
      k1r2_p4 <= radial_k1 * r2_3;
      p1uv_p4 <= tangent_p1 * uv3;
      p2uv_p4 <= tangent_p2 * uv3;
      tx4     <= clip_q(tx_s);
      ty4     <= clip_q(ty_s);
      sat4    <= sat3 | over_q(tx_s) | over_q(ty_s);
      r2_4    <= r2_3;
      u4      <= u3;
      v4      <= v3;
      obs4    <= obs3;

      // Stage 5: rescale, and the remaining tangential products.
      r4_5    <= clip_q(r4_s);
      sat5    <= sat4 | over_q(r4_s);
      k1r2_5  <= ACC_W'(k1r2_p4 >>> F);
      p1uv_5  <= ACC_W'(p1uv_p4 >>> (F - 1));
      p2uv_5  <= ACC_W'(p2uv_p4 >>> (F - 1));
      p2tx_p5 <= tangent_p2 * tx4;
      p1ty_p5 <= tangent_p1 * ty4;
      r2_5    <= r2_4;
      u5      <= u4;
      v5      <= v4;
      obs5    <= obs4;

      // Stage 6: r^6, k2 term, and the tangential offsets.
      r6_p6   <= r4_5 * r2_5;
      k2r4_p6 <= radial_k2 * r4_5;
      dpx6    <= clip_q(dpx_s);
      dpy6    <= clip_q(dpy_s);
      sat6    <= sat5 | over_q(dpx_s) | over_q(dpy_s);
      k1r2_6  <= k1r2_5;
      u6      <= u5;
      v6      <= v5;
      obs6    <= obs5;

      // Stage 7: rescale r^6 and the k2 term.
      r6_7   <= clip_q(r6_s);
      sat7   <= sat6 | over_q(r6_s);
      k2r4_7 <= ACC_W'(k2r4_p6 >>> F);
      k1r2_7 <= k1r2_6;
      dpx7   <= dpx6;
      dpy7   <= dpy6;
      u7     <= u6;
      v7     <= v6;
      obs7   <= obs6;

      // Stage 8: k3 term and the partial radial sum.
      k3r6_p8 <= radial_k3 * r6_7;
      k12_8   <= (ACC_W + 1)'(k1r2_7) + (ACC_W + 1)'(k2r4_7);
      sat8    <= sat7;
      dpx8    <= dpx7;
      dpy8    <= dpy7;
      u8      <= u7;
      v8      <= v7;
      obs8    <= obs7;

      // Stage 9: radial factor.
      dk9  <= clip_q(dk_s);
      sat9 <= sat8 | over_q(dk_s);
      dpx9 <= dpx8;
      dpy9 <= dpy8;
      u9   <= u8;
      v9   <= v8;
      obs9 <= obs8;

      // Stage 10: radial scaling of the point.
      udk_p10 <= u9 * dk9;
      vdk_p10 <= v9 * dk9;
      sat10   <= sat9;
      dpx10   <= dpx9;
      dpy10   <= dpy9;
      u10     <= u9;
      v10     <= v9;
      obs10   <= obs9;

      // Stage 11: distorted normalized point.
      ud11  <= clip_q(ud_s);
      vd11  <= clip_q(vd_s);
      sat11 <= sat10 | over_q(ud_s) | over_q(vd_s);
      obs11 <= obs10;

      // Stage 12: back to pixel scale.
      pxp12 <= ud11 * signed'({1'b0, focal_eff});
      pyp12 <= vd11 * signed'({1'b0, focal_eff});
      sat12 <= sat11;
      obs12 <= obs11;

      // Stage 13: add the principal point.
      dx13  <= clip_p(dx_s);
      dy13  <= clip_p(dy_s);
      sat13 <= sat12 | over_p(dx_s) | over_p(dy_s);
      obs13 <= obs12;

      // Output register: residuals and the beat.
      m_tdata <= {clip_p(ry_s), clip_p(rx_s), dy13, dx13};
      m_tuser <= sat13 | over_p(rx_s) | over_p(ry_s);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ldfm_checker.sv @@
// ----------------------------------------------------------------------------
// ldfm_checker: port-level checks of the lens distortion forward map
// Tracks beats in flight from the stream handshakes and checks each result
// against pending inputs, pipeline depth, backpressure and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldfm_port_checker #(
  parameter int DEPTH = 48
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  localparam int CNT_W = $clog2(DEPTH + 1) + 1;

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] inflight;
  logic [CNT_W-1:0] inflight_next;

  assign in_acc        = s_tvalid && s_tready;
  assign out_acc       = m_tvalid && m_tready;
  assign inflight_next = inflight + CNT_W'(in_acc) - CNT_W'(out_acc);

  // Beats accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  // A result is only shown for an accepted input beat.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != '0)
    else $error("output beat without a pending input beat");

  // The pipeline never holds more beats than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(DEPTH))
    else $error("more beats in flight than pipeline stages");

  // Input is taken whenever the output slot is free or draining.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output backpressure");

  // A stalled output beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind lens_distortion_forward_map ldfm_port_checker u_ldfm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
